// File: sv/bfq_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfq_pkg
// Shared types, constants and helpers for the bounded frame queue.
// -----------------------------------------------------------------------------
package bfq_pkg;

  localparam int DEPTH   = 64;
  localparam int FRAME_W = 32;
  localparam int COUNT_W = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);

  // Field widths fixed by the interface definition.
  localparam int OP_W    = 4;
  localparam int SRC_W   = 4;
  localparam int ERR_W   = 16;
  localparam int KIND_W  = 3;
  localparam int LEVEL_W = 7;
  localparam int CAP_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH    = 4'd0;
  localparam logic [OP_W-1:0] OP_READ    = 4'd1;
  localparam logic [OP_W-1:0] OP_FLUSH   = 4'd2;
  localparam logic [OP_W-1:0] OP_CLOSE   = 4'd3;
  localparam logic [OP_W-1:0] OP_INTR    = 4'd4;
  localparam logic [OP_W-1:0] OP_FAIL    = 4'd5;
  localparam logic [OP_W-1:0] OP_CB_FAIL = 4'd6;
  localparam logic [OP_W-1:0] OP_NEW_SRC = 4'd7;
  localparam logic [OP_W-1:0] OP_RET_SRC = 4'd8;

  // Read kinds.
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INTR     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SESS_ERR = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CB_ERR   = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_OLDEST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd1;

  localparam logic [SRC_W-1:0] SRC_DIRECT = 4'd0;
  localparam logic [SRC_W-1:0] SRC_LAST   = 4'd15;
  localparam logic [SRC_W-1:0] SRC_FIRST  = 4'd1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] frame;
    logic [SRC_W-1:0]   source_id;
    logic [ERR_W-1:0]   error_code;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame_out;
    logic [ERR_W-1:0]   error_out;
    logic [LEVEL_W-1:0] depth;
    logic [COUNT_W-1:0] taken;
    logic [COUNT_W-1:0] dropped;
    logic [COUNT_W-1:0] discarded;
    logic [LEVEL_W-1:0] peak_level;
    logic [SRC_W-1:0]   source_out;
    logic [LEVEL_W-1:0] flushed_count;
  } result_t;

  typedef struct packed {
    logic             drop_oldest;
    logic [CAP_W-1:0] capacity_limit;
  } cfg_t;

  typedef struct packed {
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [FRAME_W-1:0] wr_data;
    logic [PTR_W-1:0]   rd_addr;
  } mem_req_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                 input logic [COUNT_W-1:0] n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + {1'b0, n};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: sv/bfq_in_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfq_in_if
// Operation channel: valid/ready handshake with one operation per beat.
// -----------------------------------------------------------------------------
interface bfq_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfq_pkg::OP_W-1:0]     op;
  logic [bfq_pkg::FRAME_W-1:0]  frame;
  logic [bfq_pkg::SRC_W-1:0]    source_id;
  logic [bfq_pkg::ERR_W-1:0]    error_code;

  modport source (output valid, op, frame, source_id, error_code, input ready);
  modport sink   (input valid, op, frame, source_id, error_code, output ready);
endinterface
`default_nettype wire

// File: sv/bfq_out_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfq_out_if
// Result channel: valid/ready handshake with one result per beat.
// -----------------------------------------------------------------------------
interface bfq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [bfq_pkg::KIND_W-1:0]   kind;
  logic [bfq_pkg::FRAME_W-1:0]  frame_out;
  logic [bfq_pkg::ERR_W-1:0]    error_out;
  logic [bfq_pkg::LEVEL_W-1:0]  depth;
  logic [bfq_pkg::COUNT_W-1:0]  taken;
  logic [bfq_pkg::COUNT_W-1:0]  dropped;
  logic [bfq_pkg::COUNT_W-1:0]  discarded;
  logic [bfq_pkg::LEVEL_W-1:0]  peak_level;
  logic [bfq_pkg::SRC_W-1:0]    source_out;
  logic [bfq_pkg::LEVEL_W-1:0]  flushed_count;

  modport source (output valid, accepted, kind, frame_out, error_out, depth, taken,
                  dropped, discarded, peak_level, source_out, flushed_count,
                  input ready);
  modport sink   (input valid, accepted, kind, frame_out, error_out, depth, taken,
                  dropped, discarded, peak_level, source_out, flushed_count,
                  output ready);
endinterface
`default_nettype wire

// File: sv/bfq_store.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfq_store
// Frame storage with one write port and a registered head-of-queue read.
// -----------------------------------------------------------------------------
module bfq_store (
  input  wire                          clk,
  input  wire bfq_pkg::mem_req_t       req,
  output logic [bfq_pkg::FRAME_W-1:0]  head_r
);

  logic [bfq_pkg::FRAME_W-1:0] mem [bfq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // The head register always tracks the entry at the next read pointer, so a
  // frame written there in the same cycle is forwarded straight through.
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      head_r <= req.wr_data;
    end else begin
      head_r <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/bfq_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bfq_core
// Queue state, drop policy, terminal events and statistics for one operation.
// -----------------------------------------------------------------------------
module bfq_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          fire,
  input  wire bfq_pkg::item_t          item,
  input  wire bfq_pkg::cfg_t           cfg,
  input  wire [bfq_pkg::FRAME_W-1:0]   head,
  output bfq_pkg::mem_req_t            req,
  output bfq_pkg::result_t             res
);

  typedef enum logic [2:0] {
    END_NONE   = 3'd0,
    END_CLOSED = 3'd1,
    END_INTR   = 3'd2,
    END_FAILED = 3'd3,
    END_CB_ERR = 3'd4
  } end_t;

  logic [bfq_pkg::PTR_W-1:0]   rp_r, rp_nxt, wp_r, wp_nxt;
  logic [bfq_pkg::FILL_W-1:0]  fill_r, fill_nxt, peak_r, peak_nxt;
  end_t                        end_r, end_nxt;
  logic [bfq_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic [bfq_pkg::SRC_W-1:0]   src_r, src_nxt;
  logic                        open_r, open_nxt;
  logic [bfq_pkg::COUNT_W-1:0] taken_r, taken_nxt, drop_r, drop_nxt, disc_r, disc_nxt;
  logic [bfq_pkg::FILL_W-1:0]  cap;
  logic [bfq_pkg::FILL_W-1:0]  flushed;
  logic                        current;

  always_comb begin
    if (cfg.capacity_limit == '0) begin
      cap = bfq_pkg::FILL_W'(1);
    end else if (32'(cfg.capacity_limit) > 32'(bfq_pkg::DEPTH)) begin
      cap = bfq_pkg::FILL_W'(bfq_pkg::DEPTH);
    end else begin
      cap = bfq_pkg::FILL_W'(cfg.capacity_limit);
    end
  end

  assign current = (item.source_id == bfq_pkg::SRC_DIRECT) ||
                   (open_r && (item.source_id == src_r));

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    peak_nxt  = peak_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    src_nxt   = src_r;
    open_nxt  = open_r;
    taken_nxt = taken_r;
    drop_nxt  = drop_r;
    disc_nxt  = disc_r;
    flushed   = '0;
    req.wr_en   = 1'b0;
    req.wr_addr = wp_r;
    req.wr_data = item.frame;
    res.accepted  = 1'b0;
    res.kind      = bfq_pkg::KIND_NONE;
    res.frame_out = '0;
    res.error_out = '0;

    case (item.op)
      bfq_pkg::OP_PUSH: begin
        if (!current || (end_r != END_NONE)) begin
          disc_nxt = bfq_pkg::sat_add(disc_r, bfq_pkg::COUNT_W'(1));
        end else if (fill_r < cap) begin
          req.wr_en    = 1'b1;
          wp_nxt       = bfq_pkg::next_ptr(wp_r);
          fill_nxt     = fill_r + bfq_pkg::FILL_W'(1);
          res.accepted = 1'b1;
        end else if (cfg.drop_oldest && (fill_r != '0)) begin
          // Evict the oldest frame and queue the new one: the level holds.
          req.wr_en    = 1'b1;
          wp_nxt       = bfq_pkg::next_ptr(wp_r);
          rp_nxt       = bfq_pkg::next_ptr(rp_r);
          res.accepted = 1'b1;
          drop_nxt     = bfq_pkg::sat_add(drop_r, bfq_pkg::COUNT_W'(1));
        end else begin
          drop_nxt = bfq_pkg::sat_add(drop_r, bfq_pkg::COUNT_W'(1));
        end
        if (res.accepted && (fill_nxt > peak_r)) begin
          peak_nxt = fill_nxt;
        end
      end
      bfq_pkg::OP_READ: begin
        if ((end_r != END_NONE) && (end_r != END_FAILED)) begin
          case (end_r)
            END_CLOSED: res.kind = bfq_pkg::KIND_CLOSED;
            END_INTR:   res.kind = bfq_pkg::KIND_INTR;
            END_CB_ERR: begin
              res.kind      = bfq_pkg::KIND_CB_ERR;
              res.error_out = err_r;
            end
            default:    res.kind = bfq_pkg::KIND_NONE;
          endcase
        end else if (fill_r != '0) begin
          res.kind      = bfq_pkg::KIND_FRAME;
          res.frame_out = head;
          rp_nxt        = bfq_pkg::next_ptr(rp_r);
          fill_nxt      = fill_r - bfq_pkg::FILL_W'(1);
          taken_nxt     = bfq_pkg::sat_add(taken_r, bfq_pkg::COUNT_W'(1));
        end else if (end_r == END_FAILED) begin
          res.kind      = bfq_pkg::KIND_SESS_ERR;
          res.error_out = err_r;
        end else begin
          res.kind = bfq_pkg::KIND_EMPTY;
        end
      end
      bfq_pkg::OP_FLUSH: begin
        flushed  = fill_r;
        fill_nxt = '0;
        rp_nxt   = '0;
        wp_nxt   = '0;
        disc_nxt = bfq_pkg::sat_add(disc_r, bfq_pkg::COUNT_W'(fill_r));
      end
      bfq_pkg::OP_CLOSE, bfq_pkg::OP_INTR, bfq_pkg::OP_FAIL, bfq_pkg::OP_CB_FAIL: begin
        // Only the first terminal event takes effect.
        if (end_r == END_NONE) begin
          err_nxt = '0;
          case (item.op)
            bfq_pkg::OP_CLOSE: end_nxt = END_CLOSED;
            bfq_pkg::OP_INTR:  end_nxt = END_INTR;
            bfq_pkg::OP_FAIL: begin
              end_nxt = END_FAILED;
              err_nxt = item.error_code;
            end
            default: begin
              end_nxt = END_CB_ERR;
              err_nxt = item.error_code;
            end
          endcase
          if ((item.op == bfq_pkg::OP_CLOSE) || (item.op == bfq_pkg::OP_CB_FAIL)) begin
            flushed  = fill_r;
            fill_nxt = '0;
            rp_nxt   = '0;
            wp_nxt   = '0;
          end
          if (item.op != bfq_pkg::OP_FAIL) begin
            disc_nxt = bfq_pkg::sat_add(disc_r, bfq_pkg::COUNT_W'(fill_r));
          end
        end
      end
      bfq_pkg::OP_NEW_SRC: begin
        src_nxt  = (src_r == bfq_pkg::SRC_LAST) ? bfq_pkg::SRC_FIRST :
                   src_r + bfq_pkg::SRC_W'(1);
        open_nxt = 1'b1;
      end
      bfq_pkg::OP_RET_SRC: begin
        open_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    res.depth         = (end_nxt == END_INTR) ? '0 : bfq_pkg::LEVEL_W'(fill_nxt);
    res.taken         = taken_nxt;
    res.dropped       = drop_nxt;
    res.discarded     = disc_nxt;
    res.peak_level    = bfq_pkg::LEVEL_W'(peak_nxt);
    res.source_out    = src_nxt;
    res.flushed_count = bfq_pkg::LEVEL_W'(flushed);

    // Nothing moves unless the operation is actually taken this cycle.
    if (!fire) begin
      req.wr_en = 1'b0;
    end
    req.rd_addr = fire ? rp_nxt : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      fill_r  <= '0;
      peak_r  <= '0;
      end_r   <= END_NONE;
      err_r   <= '0;
      src_r   <= '0;
      open_r  <= 1'b0;
      taken_r <= '0;
      drop_r  <= '0;
      disc_r  <= '0;
    end else if (fire) begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      peak_r  <= peak_nxt;
      end_r   <= end_nxt;
      err_r   <= err_nxt;
      src_r   <= src_nxt;
      open_r  <= open_nxt;
      taken_r <= taken_nxt;
      drop_r  <= drop_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/bounded_frame_queue_with_drop.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bounded_frame_queue_with_drop
// Bounded frame queue with a configurable drop policy, terminal events and
// saturating statistics; one result beat for every operation beat.
// -----------------------------------------------------------------------------
// An accepted operation beat lands in the input register; once the result
// register is free, the queue update fills the result register with its result.
// Throughput: one operation per cycle while the result channel is ready; the
// queue update is combinational and the head read of the frame store is registered.
// Reset (synchronous, rst_n low): pointers, fill level, terminal state,
// statistics and configuration return to their defaults at once; the frame
// store is not cleared and needs no clearing pass.
module bounded_frame_queue_with_drop (
  input  wire                              clk,
  input  wire                              rst_n,
  bfq_in_if.sink                           in_chan,
  bfq_out_if.source                        out_chan,
  input  wire                              cfg_we,
  input  wire [bfq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bfq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bfq_pkg::cfg_t     cfg_r;
  bfq_pkg::item_t    item_r;
  logic              item_vld_r;
  bfq_pkg::result_t  res, res_r;
  logic              res_vld_r;
  logic              fire;
  bfq_pkg::mem_req_t req;
  logic [bfq_pkg::FRAME_W-1:0] head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_oldest    <= 1'b0;
      cfg_r.capacity_limit <= bfq_pkg::CAP_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        bfq_pkg::CFG_DROP_OLDEST: cfg_r.drop_oldest    <= cfg_data[0];
        bfq_pkg::CFG_CAPACITY:    cfg_r.capacity_limit <= bfq_pkg::CAP_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // The held operation is processed once the result register is free.
  assign fire          = item_vld_r && (!res_vld_r || out_chan.ready);
  assign in_chan.ready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.op         <= in_chan.op;
      item_r.frame      <= in_chan.frame;
      item_r.source_id  <= in_chan.source_id;
      item_r.error_code <= in_chan.error_code;
    end
  end

  bfq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .head  (head),
    .req   (req),
    .res   (res)
  );

  bfq_store u_store (
    .clk    (clk),
    .req    (req),
    .head_r (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (fire) begin
      res_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_chan.valid         = res_vld_r;
  assign out_chan.accepted      = res_r.accepted;
  assign out_chan.kind          = res_r.kind;
  assign out_chan.frame_out     = res_r.frame_out;
  assign out_chan.error_out     = res_r.error_out;
  assign out_chan.depth         = res_r.depth;
  assign out_chan.taken         = res_r.taken;
  assign out_chan.dropped       = res_r.dropped;
  assign out_chan.discarded     = res_r.discarded;
  assign out_chan.peak_level    = res_r.peak_level;
  assign out_chan.source_out    = res_r.source_out;
  assign out_chan.flushed_count = res_r.flushed_count;

endmodule
`default_nettype wire
